// File: hw/rtl/medf_pkg.sv
// ----------------------------------------------------------------------------
// medf_pkg
// Shared widths, reset values and register indexes of the median plus
// moving-average distance filter.
// ----------------------------------------------------------------------------
package medf_pkg;

    localparam int WINDOW_DEPTH_DEF = 5;

    localparam int DIST_W  = 15;
    localparam int RAW_W   = 16;
    localparam int ALPHA_W = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [DIST_W-1:0]  MIN_DISTANCE_RST      = 15'd32;
    localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST      = 15'd6400;
    localparam logic [DIST_W-1:0]  OUTLIER_THRESHOLD_RST = 15'd800;
    localparam logic [ALPHA_W-1:0] ALPHA_NORMAL_RST      = 9'd90;
    localparam logic [ALPHA_W-1:0] ALPHA_OUTLIER_RST     = 9'd26;
    localparam logic [ALPHA_W-1:0] ALPHA_FULL            = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_NORMAL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_OUTLIER     = 3'd4;

endpackage

// File: hw/rtl/median_ema_distance_filter.sv
// ----------------------------------------------------------------------------
// median_ema_distance_filter
// Distance filter: clamp, sliding-window median, then a weighted moving
// average with a separate weight for outlying medians.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries raw_distance (cm/16, negative
//   means echo timeout). Output channel out_valid/out_stall carries
//   filtered_distance, one item per input item, in order.
//   Configuration is a write port (cfg_we, cfg_index, cfg_data); write only
//   while no item is in flight.
//   An accepted item is written to the window at the accept edge, then
//   registered in the median register, then in the average/output
//   register. One item per cycle is sustained while out_stall is low; the
//   average update (one 10x16 multiply-add) closes its loop through avg_reg.
//   When out_stall is held, items stay in the three stages and in_stall
//   rises once all of them are full; nothing is dropped.
//   Reset clears the window fill count, the write slot and the seed flag,
//   sets the average to the max distance reset value and loads the register
//   reset values. No clearing pass is needed.
// ----------------------------------------------------------------------------
module median_ema_distance_filter
    import medf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [RAW_W-1:0] raw_distance,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DIST_W-1:0]     filtered_distance
);

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_DEPTH);

    logic [DIST_W-1:0]  min_distance_reg;
    logic [DIST_W-1:0]  max_distance_reg;
    logic [DIST_W-1:0]  outlier_threshold_reg;
    logic [ALPHA_W-1:0] alpha_normal_reg;
    logic [ALPHA_W-1:0] alpha_outlier_reg;

    logic [DIST_W-1:0]  window_reg [WINDOW_DEPTH];
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic [CNT_W-1:0]   filled_reg;
    logic [CNT_W-1:0]   filled_next;
    logic               win_valid_reg;

    logic [DIST_W-1:0]  med_reg;
    logic [DIST_W-1:0]  med_next;
    logic               med_valid_reg;

    logic [DIST_W-1:0]  avg_reg;
    logic [DIST_W-1:0]  avg_next;
    logic               seeded_reg;
    logic               out_valid_reg;

    logic               out_free;
    logic               med_free;
    logic               win_free;
    logic               in_accept;
    logic               med_load;
    logic               out_load;

    logic [DIST_W-1:0]  sample;
    logic [DIST_W-1:0]  sample_raised;

    logic [CNT_W-1:0]   rank [WINDOW_DEPTH];
    logic [CNT_W-1:0]   half;
    logic [CNT_W-1:0]   lo_rank;
    logic [DIST_W-1:0]  pick_hi;
    logic [DIST_W-1:0]  pick_lo;
    logic [DIST_W:0]    pair_sum;

    logic signed [DIST_W:0]       diff;
    logic [DIST_W-1:0]            dev;
    logic [ALPHA_W-1:0]           alpha_sel;
    logic [ALPHA_W-1:0]           alpha;
    logic signed [ALPHA_W+DIST_W+1:0] prod;
    logic signed [ALPHA_W+DIST_W+1:0] acc;

    // handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign med_free  = !med_valid_reg || out_free;
    assign win_free  = !win_valid_reg || med_free;
    assign in_stall  = !win_free;
    assign in_accept = in_valid && win_free;
    assign med_load  = win_valid_reg && med_free;
    assign out_load  = med_valid_reg && out_free;

    assign out_valid         = out_valid_reg;
    assign filtered_distance = avg_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg      <= MIN_DISTANCE_RST;
            max_distance_reg      <= MAX_DISTANCE_RST;
            outlier_threshold_reg <= OUTLIER_THRESHOLD_RST;
            alpha_normal_reg      <= ALPHA_NORMAL_RST;
            alpha_outlier_reg     <= ALPHA_OUTLIER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_DISTANCE:      min_distance_reg      <= cfg_data;
                REG_MAX_DISTANCE:      max_distance_reg      <= cfg_data;
                REG_OUTLIER_THRESHOLD: outlier_threshold_reg <= cfg_data;
                REG_ALPHA_NORMAL:      alpha_normal_reg      <= cfg_data[ALPHA_W-1:0];
                REG_ALPHA_OUTLIER:     alpha_outlier_reg     <= cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp: negative input to max, then raise to min, then lower to max
    always_comb
    begin
        sample_raised = raw_distance[RAW_W-1] ? max_distance_reg
                                               : raw_distance[DIST_W-1:0];
        if (sample_raised < min_distance_reg)
        begin
            sample_raised = min_distance_reg;
        end
        sample = (sample_raised > max_distance_reg) ? max_distance_reg : sample_raised;
    end

    assign slot_next   = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
    assign filled_next = (filled_reg == FULL_CNT) ? filled_reg : filled_reg + CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            window_reg[slot_reg] <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            filled_reg    <= '0;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                slot_reg   <= slot_next;
                filled_reg <= filled_next;
            end
            if (win_free)
            begin
                win_valid_reg <= in_valid;
            end
        end
    end

    // median by rank selection over the filled slots
    always_comb
    begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_DEPTH; j++)
            begin
                if (j != i && CNT_W'(j) < filled_reg &&
                    (window_reg[j] < window_reg[i] ||
                     (window_reg[j] == window_reg[i] && j < i)))
                begin
                    rank[i] = rank[i] + CNT_W'(1);
                end
            end
        end
    end

    assign half    = filled_reg >> 1;
    assign lo_rank = half - CNT_W'(1);

    always_comb
    begin
        pick_hi = '0;
        pick_lo = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            if (CNT_W'(i) < filled_reg && rank[i] == half)
            begin
                pick_hi = pick_hi | window_reg[i];
            end
            if (CNT_W'(i) < filled_reg && rank[i] == lo_rank)
            begin
                pick_lo = pick_lo | window_reg[i];
            end
        end
        pair_sum = {1'b0, pick_lo} + {1'b0, pick_hi};
        med_next = filled_reg[0] ? pick_hi : pair_sum[DIST_W:1];
    end

    always_ff @(posedge clk)
    begin
        if (med_load)
        begin
            med_reg <= med_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            med_valid_reg <= 1'b0;
        end
        else if (med_free)
        begin
            med_valid_reg <= win_valid_reg;
        end
    end

    // average: avg + (alpha*(med-avg) + 128) >> 8, seeded with the first median
    always_comb
    begin
        diff      = $signed({1'b0, med_reg}) - $signed({1'b0, avg_reg});
        dev       = diff[DIST_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];
        alpha_sel = (dev > outlier_threshold_reg) ? alpha_outlier_reg : alpha_normal_reg;
        alpha     = (alpha_sel > ALPHA_FULL) ? ALPHA_FULL : alpha_sel;
        prod      = $signed({1'b0, alpha}) * diff;
        acc       = $signed({3'b000, avg_reg, 8'd0}) + prod
                  + $signed((ALPHA_W+DIST_W+2)'(128));
        avg_next  = seeded_reg ? acc[DIST_W+7:8] : med_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg       <= MAX_DISTANCE_RST;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                avg_reg    <= avg_next;
                seeded_reg <= 1'b1;
            end
            if (out_free)
            begin
                out_valid_reg <= med_valid_reg;
            end
        end
    end

endmodule
